// ----- rtl/eppsm_pkg.sv -----
// Shared types, codes and helpers for the packet parser / servo map block.
// No dependencies; imported by every module of the block.
`default_nettype none

package eppsm_pkg;

  // Framing and row codes
  localparam logic [7:0] SYNC_BYTE       = 8'hAA;
  localparam logic [7:0] CODE_QUALITY    = 8'h02;
  localparam logic [7:0] CODE_ATTENTION  = 8'h04;
  localparam logic [7:0] CODE_MEDITATION = 8'h05;
  localparam logic [7:0] CODE_POWER      = 8'h83;
  localparam logic [7:0] CODE_EXT_MIN    = 8'h80;
  localparam logic [7:0] CHECK_EMPTY     = 8'hFF;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_LED_THRESHOLD    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIAL_AT_ZERO     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIAL_AT_FULL     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_THROTTLE_AT_ZERO = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_THROTTLE_AT_FULL = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD_LEN  = 3'd5;

  // Configuration reset values
  localparam logic [6:0] RST_LED_THRESHOLD    = 7'd40;
  localparam logic [7:0] RST_DIAL_AT_ZERO     = 8'd145;
  localparam logic [7:0] RST_DIAL_AT_FULL     = 8'd55;
  localparam logic [7:0] RST_THROTTLE_AT_ZERO = 8'd150;
  localparam logic [7:0] RST_THROTTLE_AT_FULL = 8'd5;
  localparam logic [7:0] RST_MAX_PAYLOAD_LEN  = 8'd169;

  // Attention range that produces a result, and PWM saturation point
  localparam logic [7:0] ATT_LIMIT = 8'd100;
  localparam logic [7:0] MED_SAT   = 8'd100;
  localparam logic [7:0] PWM_MAX   = 8'hFF;

  // Reciprocal of 100: floor(x * 5243 / 2^19) is exact for x below 2^15
  localparam logic [12:0] RECIP_100       = 13'd5243;
  localparam int unsigned RECIP_100_SHIFT = 19;

  typedef enum logic [6:0] {
    PH_HUNT1 = 7'b0000001,
    PH_HUNT2 = 7'b0000010,
    PH_LEN   = 7'b0000100,
    PH_CODE  = 7'b0001000,
    PH_VLEN  = 7'b0010000,
    PH_VALUE = 7'b0100000,
    PH_CHECK = 7'b1000000
  } phase_t;

  typedef struct packed {
    logic [6:0] led_threshold;
    logic [7:0] dial_at_zero;
    logic [7:0] dial_at_full;
    logic [7:0] throttle_at_zero;
    logic [7:0] throttle_at_full;
    logic [7:0] max_payload_length;
  } cfg_t;

  // Committed levels of one packet that qualifies for a result
  typedef struct packed {
    logic [6:0] attention;
    logic [7:0] meditation;
    logic [7:0] quality;
  } levels_t;

  typedef struct packed {
    logic [6:0] attention_level;
    logic [7:0] meditation_level;
    logic [7:0] signal_quality;
    logic       led_on;
    logic [7:0] dial_angle;
    logic [7:0] throttle_angle;
    logic [7:0] attention_pwm;
    logic [7:0] meditation_pwm;
  } result_t;

  // x / 100 for x below 2^15, quotient fits 8 bits for x up to 25599
  function automatic logic [7:0] div100(input logic [14:0] x);
    logic [27:0] prod;
    prod = 28'(x) * 28'(RECIP_100);
    return prod[RECIP_100_SHIFT +: 8];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/eppsm_parser.sv -----
// Byte-level packet parser: sync hunt, length, row decode, checksum, commit.
// Depends on eppsm_pkg. Emits one registered levels beat per qualifying packet.
`default_nettype none

module eppsm_parser (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              accept,
  input  wire logic              adv,
  input  wire logic [7:0]        rx_byte,
  input  wire eppsm_pkg::cfg_t   cfg,
  output logic                   lv_vld,
  output eppsm_pkg::levels_t     lv
);
  import eppsm_pkg::*;

  phase_t     phase_r, phase_nxt;
  logic [7:0] pay_left_r, pay_left_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic [7:0] row_code_r, row_code_nxt;
  logic [7:0] row_left_r, row_left_nxt;
  logic [7:0] stg_att_r, stg_att_nxt;
  logic [7:0] stg_med_r, stg_med_nxt;
  logic [7:0] stg_qual_r, stg_qual_nxt;
  logic       stg_pwr_r, stg_pwr_nxt;
  logic [7:0] hld_att_r, hld_att_nxt;
  logic [7:0] hld_med_r, hld_med_nxt;
  logic [7:0] hld_qual_r, hld_qual_nxt;
  logic       emit;
  logic [7:0] row_left_dec;

  logic       lv_vld_r;
  levels_t    lv_r;

  // Next-state logic for one accepted byte
  always_comb begin
    phase_nxt    = phase_r;
    pay_left_nxt = pay_left_r;
    sum_nxt      = sum_r;
    row_code_nxt = row_code_r;
    row_left_nxt = row_left_r;
    stg_att_nxt  = stg_att_r;
    stg_med_nxt  = stg_med_r;
    stg_qual_nxt = stg_qual_r;
    stg_pwr_nxt  = stg_pwr_r;
    hld_att_nxt  = hld_att_r;
    hld_med_nxt  = hld_med_r;
    hld_qual_nxt = hld_qual_r;
    emit         = 1'b0;
    row_left_dec = row_left_r - 8'd1;

    case (phase_r)
      PH_HUNT1: begin
        if (rx_byte == SYNC_BYTE) phase_nxt = PH_HUNT2;
      end
      PH_HUNT2: begin
        phase_nxt = (rx_byte == SYNC_BYTE) ? PH_LEN : PH_HUNT1;
      end
      PH_LEN: begin
        if (rx_byte > cfg.max_payload_length) begin
          phase_nxt = PH_HUNT1;
        end else begin
          pay_left_nxt = rx_byte;
          sum_nxt      = '0;
          row_code_nxt = '0;
          row_left_nxt = '0;
          stg_att_nxt  = hld_att_r;
          stg_med_nxt  = hld_med_r;
          stg_qual_nxt = hld_qual_r;
          stg_pwr_nxt  = 1'b0;
          phase_nxt    = (rx_byte == 8'd0) ? PH_CHECK : PH_CODE;
        end
      end
      PH_CODE, PH_VLEN, PH_VALUE: begin
        sum_nxt      = sum_r + rx_byte;
        pay_left_nxt = pay_left_r - 8'd1;
        if (phase_r == PH_CODE) begin
          row_code_nxt = rx_byte;
          if (rx_byte < CODE_EXT_MIN) begin
            row_left_nxt = 8'd1;
            phase_nxt    = PH_VALUE;
          end else begin
            phase_nxt = PH_VLEN;
          end
        end else if (phase_r == PH_VLEN) begin
          row_left_nxt = rx_byte;
          if (rx_byte == 8'd0) begin
            if (row_code_r == CODE_POWER) stg_pwr_nxt = 1'b1;
            phase_nxt = PH_CODE;
          end else begin
            phase_nxt = PH_VALUE;
          end
        end else begin
          // value byte; only single-byte rows stage a level
          if (row_code_r == CODE_QUALITY)    stg_qual_nxt = rx_byte;
          if (row_code_r == CODE_ATTENTION)  stg_att_nxt  = rx_byte;
          if (row_code_r == CODE_MEDITATION) stg_med_nxt  = rx_byte;
          row_left_nxt = row_left_dec;
          if (row_left_dec == 8'd0) begin
            if (row_code_r == CODE_POWER) stg_pwr_nxt = 1'b1;
            phase_nxt = PH_CODE;
          end
        end
        // payload end cuts off any open row
        if (pay_left_nxt == 8'd0) phase_nxt = PH_CHECK;
      end
      PH_CHECK: begin
        phase_nxt = PH_HUNT1;
        if (rx_byte == ~sum_r) begin
          hld_att_nxt  = stg_att_r;
          hld_med_nxt  = stg_med_r;
          hld_qual_nxt = stg_qual_r;
          emit = stg_pwr_r && (stg_att_r != 8'd0) && (stg_att_r < ATT_LIMIT);
        end
      end
      default: begin
        phase_nxt = PH_HUNT1;
      end
    endcase
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HUNT1;
      pay_left_r <= '0;
      sum_r      <= '0;
      row_code_r <= '0;
      row_left_r <= '0;
      stg_att_r  <= '0;
      stg_med_r  <= '0;
      stg_qual_r <= '0;
      stg_pwr_r  <= 1'b0;
      hld_att_r  <= '0;
      hld_med_r  <= '0;
      hld_qual_r <= '0;
    end else if (accept) begin
      phase_r    <= phase_nxt;
      pay_left_r <= pay_left_nxt;
      sum_r      <= sum_nxt;
      row_code_r <= row_code_nxt;
      row_left_r <= row_left_nxt;
      stg_att_r  <= stg_att_nxt;
      stg_med_r  <= stg_med_nxt;
      stg_qual_r <= stg_qual_nxt;
      stg_pwr_r  <= stg_pwr_nxt;
      hld_att_r  <= hld_att_nxt;
      hld_med_r  <= hld_med_nxt;
      hld_qual_r <= hld_qual_nxt;
    end
  end

  // Levels beat register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lv_vld_r <= 1'b0;
    end else if (adv) begin
      lv_vld_r <= accept && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lv_r.attention  <= stg_att_r[6:0];
      lv_r.meditation <= stg_med_r;
      lv_r.quality    <= stg_qual_r;
    end
  end

  assign lv_vld = lv_vld_r;
  assign lv     = lv_r;

endmodule

`default_nettype wire

// ----- rtl/eppsm_map.sv -----
// Maps committed levels to LED, servo angles and PWM levels in two stages.
// Depends on eppsm_pkg. Owns the result register of the block.
`default_nettype none

module eppsm_map (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               adv,
  input  wire logic               lv_vld,
  input  wire eppsm_pkg::levels_t lv,
  input  wire eppsm_pkg::cfg_t    cfg,
  output logic                    res_vld,
  output eppsm_pkg::result_t      res
);
  import eppsm_pkg::*;

  // Signed product a * (at_full - at_zero) as sign and magnitude
  function automatic logic [15:0] span_prod(input logic [6:0] a,
                                            input logic [7:0] at_zero,
                                            input logic [7:0] at_full);
    logic signed [8:0]  span;
    logic signed [16:0] prod;
    logic [16:0]        mag;
    span = $signed({1'b0, at_full}) - $signed({1'b0, at_zero});
    prod = $signed({1'b0, a}) * span;
    mag  = prod[16] ? 17'(-prod) : 17'(prod);
    return {prod[16], mag[14:0]};
  endfunction

  logic        b_vld_r;
  levels_t     b_lv_r;
  logic        b_led_r;
  logic [15:0] b_dial_r;
  logic [15:0] b_thr_r;
  logic [14:0] b_apwm_x_r;
  logic [14:0] b_mpwm_x_r;
  logic        b_msat_r;
  logic [15:0] apwm_x;
  logic [15:0] mpwm_x;

  logic        res_vld_r;
  result_t     res_r, res_nxt;
  logic [7:0]  dial_q;
  logic [7:0]  thr_q;

  // 255 * level as a shift and subtract
  assign apwm_x = {1'b0, lv.attention, 8'd0} - 16'(lv.attention);
  assign mpwm_x = {lv.meditation, 8'd0} - 16'(lv.meditation);

  // Stage B: products
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (adv) begin
      b_vld_r <= lv_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_lv_r     <= lv;
      b_led_r    <= lv.attention > cfg.led_threshold;
      b_dial_r   <= span_prod(lv.attention, cfg.dial_at_zero, cfg.dial_at_full);
      b_thr_r    <= span_prod(lv.attention, cfg.throttle_at_zero, cfg.throttle_at_full);
      b_apwm_x_r <= apwm_x[14:0];
      b_mpwm_x_r <= mpwm_x[14:0];
      b_msat_r   <= lv.meditation > MED_SAT;
    end
  end

  // Result stage: divide by 100 toward zero, offset, saturate
  always_comb begin
    dial_q = div100(b_dial_r[14:0]);
    thr_q  = div100(b_thr_r[14:0]);
    res_nxt.attention_level  = b_lv_r.attention;
    res_nxt.meditation_level = b_lv_r.meditation;
    res_nxt.signal_quality   = b_lv_r.quality;
    res_nxt.led_on           = b_led_r;
    res_nxt.dial_angle       = b_dial_r[15] ? cfg.dial_at_zero - dial_q
                                            : cfg.dial_at_zero + dial_q;
    res_nxt.throttle_angle   = b_thr_r[15] ? cfg.throttle_at_zero - thr_q
                                           : cfg.throttle_at_zero + thr_q;
    res_nxt.attention_pwm    = div100(b_apwm_x_r);
    res_nxt.meditation_pwm   = b_msat_r ? PWM_MAX : div100(b_mpwm_x_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_vld_r <= 1'b0;
    end else if (adv) begin
      res_vld_r <= b_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res_nxt;
    end
  end

  assign res_vld = res_vld_r;
  assign res     = res_r;

endmodule

`default_nettype wire

// ----- rtl/eeg_packet_parser_servo_map.sv -----
// Top level of the packet parser / servo map block: ports and config registers.
// Depends on eppsm_pkg, eppsm_parser and eppsm_map.
//
// Takes one received byte per cycle. Bytes are framed by two sync bytes, a
// length, the payload rows and a checksum; a packet with a good checksum, a
// power-band row and attention 1 to 99 yields one result beat carrying the
// committed levels, LED state, both servo angles and both PWM levels. The
// beat passes through the parser's output register, which loads at the clock
// edge that takes the checksum byte, then a product stage and then the
// result register, where it is valid. The pipeline moves as a whole, so a
// byte is taken every cycle unless the result register holds a beat that is
// stalled; then in_stall rises until that beat leaves.
// Configuration writes are always ready and take effect at once; write only
// while no packet is in flight. Indexes beyond the last register are ignored.
`default_nettype none

module eeg_packet_parser_servo_map (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // byte input
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [7:0]                      in_rx_byte,
  // result output
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [6:0]                           out_attention_level,
  output logic [7:0]                           out_meditation_level,
  output logic [7:0]                           out_signal_quality,
  output logic                                 out_led_on,
  output logic [7:0]                           out_dial_angle,
  output logic [7:0]                           out_throttle_angle,
  output logic [7:0]                           out_attention_pwm,
  output logic [7:0]                           out_meditation_pwm,
  // configuration writes
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [eppsm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]                      cfg_data
);
  import eppsm_pkg::*;

  cfg_t    cfg_r;
  logic    adv;
  logic    accept;
  logic    lv_vld;
  levels_t lv;
  logic    res_vld;
  result_t res;

  // Pipeline advances unless the result beat is held
  assign adv      = !res_vld || !out_stall;
  assign in_stall = !adv;
  assign accept   = in_valid && adv;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.led_threshold      <= RST_LED_THRESHOLD;
      cfg_r.dial_at_zero       <= RST_DIAL_AT_ZERO;
      cfg_r.dial_at_full       <= RST_DIAL_AT_FULL;
      cfg_r.throttle_at_zero   <= RST_THROTTLE_AT_ZERO;
      cfg_r.throttle_at_full   <= RST_THROTTLE_AT_FULL;
      cfg_r.max_payload_length <= RST_MAX_PAYLOAD_LEN;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_LED_THRESHOLD:    cfg_r.led_threshold      <= cfg_data[6:0];
        CFG_DIAL_AT_ZERO:     cfg_r.dial_at_zero       <= cfg_data;
        CFG_DIAL_AT_FULL:     cfg_r.dial_at_full       <= cfg_data;
        CFG_THROTTLE_AT_ZERO: cfg_r.throttle_at_zero   <= cfg_data;
        CFG_THROTTLE_AT_FULL: cfg_r.throttle_at_full   <= cfg_data;
        CFG_MAX_PAYLOAD_LEN:  cfg_r.max_payload_length <= cfg_data;
        default: ;
      endcase
    end
  end

  eppsm_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .adv     (adv),
    .rx_byte (in_rx_byte),
    .cfg     (cfg_r),
    .lv_vld  (lv_vld),
    .lv      (lv)
  );

  eppsm_map u_map (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .lv_vld  (lv_vld),
    .lv      (lv),
    .cfg     (cfg_r),
    .res_vld (res_vld),
    .res     (res)
  );

  // Result ports
  assign out_valid            = res_vld;
  assign out_attention_level  = res.attention_level;
  assign out_meditation_level = res.meditation_level;
  assign out_signal_quality   = res.signal_quality;
  assign out_led_on           = res.led_on;
  assign out_dial_angle       = res.dial_angle;
  assign out_throttle_angle   = res.throttle_angle;
  assign out_attention_pwm    = res.attention_pwm;
  assign out_meditation_pwm   = res.meditation_pwm;

endmodule

`default_nettype wire
